[rtl/nstab_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nstab_pkg
// Shared constants and codes of the scaling / tiling blit unit.
// ----------------------------------------------------------------------------
package nstab_pkg;

	localparam int SourcePixels = 65536;
	localparam int AddrBits     = $clog2(SourcePixels);
	localparam int MaxTargetDim = 1024;

	typedef enum logic [2:0] {
		REG_SOURCE_WIDTH  = 3'd0,
		REG_SOURCE_HEIGHT = 3'd1,
		REG_TARGET_WIDTH  = 3'd2,
		REG_TARGET_HEIGHT = 3'd3,
		REG_TILE_MODE     = 3'd4
	} reg_index_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_RENDER = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		BL_SRC   = 2'd0,
		BL_UNDER = 2'd1,
		BL_MIX   = 2'd2
	} blend_sel_t;

endpackage

[rtl/nearest_scale_tile_alpha_blit_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_scale_tile_alpha_blit_unit
// Nearest-neighbor scaler / tiler over a source pixel store, alpha blend.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): a load beat writes one RGBA pixel at
//    source_index; a render beat names out_x/out_y and the color beneath.
//  - Output channel (out_valid/out_ready): one pixel_color beat per render,
//    in input order; loads give no beat.
//  - Configuration: cfg_we/cfg_index/cfg_data write a register;
//    write only while no item is in flight.
//  - Throughput: one beat per cycle, sustained while the receiver takes
//    every beat. A render passes through the coordinate divider (one
//    quotient bit a stage, plus an overflow stage), the address
//    multiply, the store read and two blend stages.
//  - Loads and renders share one pipeline and meet the store at the same
//    stage, so a render always sees every load accepted before it.
//  - Receiver stall: while the output register holds an untaken beat the
//    whole pipeline holds and in_ready drops; bubbles keep their slots.
//  - Reset clears pipeline valids and tile mode, sets sizes to one; the
//    store itself is not cleared, an entry reads as garbage until loaded.
// ----------------------------------------------------------------------------
module nearest_scale_tile_alpha_blit_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [15:0] source_index,
	input  logic [7:0]  source_red,
	input  logic [7:0]  source_green,
	input  logic [7:0]  source_blue,
	input  logic [7:0]  source_alpha,
	input  logic [9:0]  out_x,
	input  logic [9:0]  out_y,
	input  logic [23:0] under_color,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] pixel_color
);
	import nstab_pkg::*;

	localparam int DivLast = 11;  // last divider stage
	localparam int MemStg  = 13;  // stage that meets the store

	// step of the restoring divider: subtract shifted divisor if it fits
	function automatic logic [19:0] try_sub(input logic [18:0] r, input logic [20:0] dk);
		logic hit;
		logic [18:0] nr;
		hit = {2'b00, r} >= dk;
		nr  = hit ? (r - dk[18:0]) : r;
		return {hit, nr};
	endfunction

	// configuration
	logic [8:0]  sw_q, sh_q;
	logic [10:0] tw_q, th_q;
	logic        tile_q;
	logic [8:0]  sw, sh;
	logic [10:0] tw, th;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q   <= 9'd1;
			sh_q   <= 9'd1;
			tw_q   <= 11'd1;
			th_q   <= 11'd1;
			tile_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_WIDTH:  sw_q   <= cfg_data[8:0];
				REG_SOURCE_HEIGHT: sh_q   <= cfg_data[8:0];
				REG_TARGET_WIDTH:  tw_q   <= cfg_data;
				REG_TARGET_HEIGHT: th_q   <= cfg_data;
				REG_TILE_MODE:     tile_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// zero reads as one, targets saturate at the largest dimension
	assign sw = (sw_q == 9'd0) ? 9'd1 : sw_q;
	assign sh = (sh_q == 9'd0) ? 9'd1 : sh_q;
	assign tw = (tw_q == 11'd0) ? 11'd1 :
		(tw_q > 11'(MaxTargetDim)) ? 11'(MaxTargetDim) : tw_q;
	assign th = (th_q == 11'd0) ? 11'd1 :
		(th_q > 11'(MaxTargetDim)) ? 11'(MaxTargetDim) : th_q;

	// pipeline advance: hold everything while the output beat waits
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// payload and divider state per stage
	logic        v_s    [0:MemStg];
	logic        op_s   [0:MemStg];
	logic [15:0] idx_s  [0:MemStg];
	logic [31:0] dat_s  [0:MemStg];
	logic [23:0] und_s  [0:MemStg];
	logic [18:0] xr_s   [0:DivLast];
	logic [18:0] yr_s   [0:DivLast];
	logic [9:0]  xq_s   [0:DivLast];
	logic [9:0]  yq_s   [0:DivLast];
	logic        xo_s   [0:DivLast];
	logic        yo_s   [0:DivLast];
	logic [10:0] xd_s   [0:DivLast];
	logic [10:0] yd_s   [0:DivLast];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= MemStg; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 1; i <= MemStg; i++) v_s[i] <= v_s[i-1];
		end
	end

	// stage 0: dividend and divisor per axis
	always_ff @(posedge clk) begin
		if (en) begin
			op_s[0]  <= operation;
			idx_s[0] <= source_index;
			dat_s[0] <= {source_red, source_green, source_blue, source_alpha};
			und_s[0] <= under_color;
			if (tile_q) begin
				xr_s[0] <= {9'd0, out_x};
				yr_s[0] <= {9'd0, out_y};
				xd_s[0] <= {2'b00, sw};
				yd_s[0] <= {2'b00, sh};
			end else begin
				xr_s[0] <= out_x * sw;
				yr_s[0] <= out_y * sh;
				xd_s[0] <= tw;
				yd_s[0] <= th;
			end
			xq_s[0] <= '0;
			yq_s[0] <= '0;
			xo_s[0] <= 1'b0;
			yo_s[0] <= 1'b0;
		end
	end

	// stages 1..13 carry the payload; stages 1..11 divide: overflow check, then one quotient bit a stage
	for (genvar p = 1; p <= MemStg; p++) begin : g_carry
		always_ff @(posedge clk) begin
			if (en) begin
				op_s[p]  <= op_s[p-1];
				idx_s[p] <= idx_s[p-1];
				dat_s[p] <= dat_s[p-1];
				und_s[p] <= und_s[p-1];
			end
		end
	end

	for (genvar p = 1; p <= DivLast; p++) begin : g_div
		localparam int K = (p == 1) ? 10 : DivLast - p;
		logic [19:0] xs, ys;
		assign xs = try_sub(xr_s[p-1], {10'd0, xd_s[p-1]} << K);
		assign ys = try_sub(yr_s[p-1], {10'd0, yd_s[p-1]} << K);
		always_ff @(posedge clk) begin
			if (en) begin
				xd_s[p] <= xd_s[p-1];
				yd_s[p] <= yd_s[p-1];
				if (p == 1) begin
					// quotient too big for ten bits: clamps anyway
					xo_s[p] <= xs[19];
					yo_s[p] <= ys[19];
					xr_s[p] <= xr_s[p-1];
					yr_s[p] <= yr_s[p-1];
					xq_s[p] <= xq_s[p-1];
					yq_s[p] <= yq_s[p-1];
				end else begin
					xo_s[p] <= xo_s[p-1];
					yo_s[p] <= yo_s[p-1];
					xr_s[p] <= xs[18:0];
					yr_s[p] <= ys[18:0];
					xq_s[p] <= xq_s[p-1] | (10'(xs[19]) << K);
					yq_s[p] <= yq_s[p-1] | (10'(ys[19]) << K);
				end
			end
		end
	end

	// stage 12: source coordinate, clamp in scale mode, remainder in tile mode
	logic [8:0] sx_s12, sy_s12;
	always_ff @(posedge clk) begin
		if (en) begin
			if (tile_q) begin
				sx_s12 <= xr_s[DivLast][8:0];
				sy_s12 <= yr_s[DivLast][8:0];
			end else begin
				sx_s12 <= (xo_s[DivLast] || xq_s[DivLast] >= {1'b0, sw}) ?
					sw - 9'd1 : xq_s[DivLast][8:0];
				sy_s12 <= (yo_s[DivLast] || yq_s[DivLast] >= {1'b0, sh}) ?
					sh - 9'd1 : yq_s[DivLast][8:0];
			end
		end
	end

	// stage 13: row-major fetch address
	logic [18:0] addr_s13;
	always_ff @(posedge clk) begin
		if (en) addr_s13 <= 19'(sy_s12 * sw) + {10'd0, sx_s12};
	end

	// stage 14: source store, loads write and renders read at one slot
	logic [31:0] store [0:SourcePixels-1];
	logic [31:0] rd_s14;
	logic [23:0] und_s14;
	logic        inr_s14;
	logic        rv_s14;

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s[MemStg] && op_s[MemStg] == OP_LOAD)
				store[idx_s[MemStg][AddrBits-1:0]] <= dat_s[MemStg];
			rd_s14 <= store[addr_s13[AddrBits-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			und_s14 <= und_s[MemStg];
			inr_s14 <= (addr_s13 >> AddrBits) == 19'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_s14 <= 1'b0;
		else if (en) rv_s14 <= v_s[MemStg] && op_s[MemStg] == OP_RENDER;
	end

	// stage 15: per-channel weighted sums; blue is channel 0
	logic [15:0]  t_s15 [0:2];
	logic [23:0]  src_s15, und_s15;
	blend_sel_t   sel_s15;
	logic         rv_s15;
	logic [7:0]   a14;
	assign a14 = rd_s14[7:0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				t_s15[j] <= {8'd0, rd_s14[8+8*j +: 8]} * {8'd0, a14} +
					{8'd0, und_s14[8*j +: 8]} * {8'd0, 8'hff - a14};
			src_s15 <= rd_s14[31:8];
			und_s15 <= und_s14;
			// out-of-store fetch reads as transparent black
			if (!inr_s14 || a14 == 8'd0) sel_s15 <= BL_UNDER;
			else if (a14 == 8'hff)       sel_s15 <= BL_SRC;
			else                         sel_s15 <= BL_MIX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_s15 <= 1'b0;
		else if (en) rv_s15 <= rv_s14;
	end

	// stage 16: divide by 255 through the reciprocal, drive the output beat
	logic [23:0] mix;
	always_comb begin
		logic [32:0] prod;
		mix = '0;
		for (int j = 0; j < 3; j++) begin
			prod = {17'd0, t_s15[j]} * 33'h0_0000_8081;
			mix[8*j +: 8] = prod[30:23];
		end
	end

	logic        out_valid_q;
	logic [23:0] pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= rv_s15;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (sel_s15)
				BL_SRC:   pixel_q <= src_s15;
				BL_UNDER: pixel_q <= und_s15;
				BL_MIX:   pixel_q <= mix;
				default:  pixel_q <= und_s15;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_color = pixel_q;

endmodule
